FILE: hdl/bcs_pkg.sv
package bcs_pkg;

    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    // operation codes
    localparam logic [1:0] OP_BODY   = 2'd0;
    localparam logic [1:0] OP_SWITCH = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // mode codes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_DRIVE = 2'd1;
    localparam logic [1:0] MODE_FAULT = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INPUT_TIMEOUT  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SWITCH_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DARKNESS       = 2'd2;

    localparam logic [15:0] INPUT_TIMEOUT_RESET  = 16'd100;
    localparam logic [15:0] SWITCH_TIMEOUT_RESET = 16'd100;
    localparam logic [6:0]  DARKNESS_RESET       = 7'd30;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] time_now;
        logic [3:0]  rolling_count;
        logic        driver_door_open;
        logic        passenger_door_open;
        logic [6:0]  ambient_level;
        logic        ignition;
        logic        unlock_press;
        logic        lock_press;
        logic        hazard_press;
        logic        manual_lights;
        logic        auto_lights;
    } bcs_in_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       locked;
        logic       cabin_light;
        logic       head_lamps;
        logic       hazard_lamps;
        logic       diag_fault;
        logic [3:0] status_count;
    } bcs_out_t;

    typedef struct packed {
        logic       driver_door_open;
        logic       passenger_door_open;
        logic [6:0] ambient_level;
        logic       ignition;
    } bcs_body_t;

    typedef struct packed {
        logic unlock_press;
        logic lock_press;
        logic hazard_press;
        logic manual_lights;
        logic auto_lights;
    } bcs_switch_t;

    // per-message supervision status
    typedef struct packed {
        logic seen;
        logic stale;
        logic cnt_fault;
    } bcs_track_t;

endpackage

FILE: hdl/bcs_msg_tracker.sv
module bcs_msg_tracker
    import bcs_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  logic [3:0]  rolling_count,
    input  logic [31:0] time_now,
    input  logic [15:0] timeout,
    output bcs_track_t  status
);

    logic                 seen_reg, seen_next;
    logic [3:0]           last_count_reg, last_count_next;
    logic                 cnt_fault_reg, cnt_fault_next;
    logic [TIME_BITS-1:0] arrival_reg, arrival_next;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;

    assign now_t   = TIME_BITS'(time_now);
    // wrapping age of the last message
    assign elapsed = now_t - arrival_reg;

    always_comb begin
        seen_next       = seen_reg;
        last_count_next = last_count_reg;
        cnt_fault_next  = cnt_fault_reg;
        arrival_next    = arrival_reg;
        if (load) begin
            if (seen_reg && (rolling_count != last_count_reg + 4'd1)) begin
                cnt_fault_next = 1'b1;
            end
            seen_next       = 1'b1;
            last_count_next = rolling_count;
            arrival_next    = now_t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg       <= 1'b0;
            last_count_reg <= '0;
            cnt_fault_reg  <= 1'b0;
            arrival_reg    <= '0;
        end else begin
            seen_reg       <= seen_next;
            last_count_reg <= last_count_next;
            cnt_fault_reg  <= cnt_fault_next;
            arrival_reg    <= arrival_next;
        end
    end

    assign status.seen      = seen_reg;
    assign status.stale     = !seen_reg || (elapsed > TIME_BITS'(timeout));
    assign status.cnt_fault = cnt_fault_reg;

endmodule

FILE: hdl/body_control_supervisor.sv
// Body control supervisor.
// Input channel s_valid/s_ready/s_data carries body-input messages, driver-switch
// messages and ticks. Messages update the stored body and switch state and give
// no result; each tick gives one status result on m_valid/m_ready/m_data.
// Operation code three is dropped without effect.
// Configuration (timeouts and darkness threshold) is written through
// cfg_wr_en/cfg_index/cfg_wr_data. It must be written only while the block
// is idle; the block itself does not enforce this. An item is captured in the
// input register, evaluated against the stored state once it can advance, and
// the tick result is registered. One item per cycle is taken, limited only by
// the result register: a tick waits in the input register while an untaken
// result is held, messages pass regardless.
// A stalled receiver therefore stops the input side only once a tick meets a
// full result register. Reset (aresetn low, synchronous) empties both
// registers, clears all message state and counters, unlocks the latch and
// loads the register defaults (timeouts 100 ms, threshold 30 percent).
module body_control_supervisor
    import bcs_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  bcs_in_t                   s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output bcs_out_t                  m_data,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wr_data
);

    logic        in_valid_reg, in_valid_next;
    bcs_in_t     in_data_reg;
    logic        out_valid_reg, out_valid_next;
    bcs_out_t    out_data_reg;
    logic [15:0] in_timeout_reg;
    logic [15:0] sw_timeout_reg;
    logic [6:0]  dark_reg;
    bcs_body_t   body_reg, body_next;
    bcs_switch_t switch_reg, switch_next;
    logic        lock_reg, lock_next;
    logic [3:0]  alive_reg, alive_next;

    logic        advance;
    logic        is_body, is_switch, is_tick;
    bcs_track_t  body_trk, switch_trk;
    logic        fault;
    logic        door_open;
    bcs_out_t    result;

    assign is_body   = in_data_reg.operation == OP_BODY;
    assign is_switch = in_data_reg.operation == OP_SWITCH;
    assign is_tick   = in_data_reg.operation == OP_TICK;

    // only a tick needs room in the result register
    assign advance = in_valid_reg && (!is_tick || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    bcs_msg_tracker #(.TIME_BITS(TIME_BITS)) u_body_trk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance && is_body),
        .rolling_count (in_data_reg.rolling_count),
        .time_now      (in_data_reg.time_now),
        .timeout       (in_timeout_reg),
        .status        (body_trk)
    );

    bcs_msg_tracker #(.TIME_BITS(TIME_BITS)) u_switch_trk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance && is_switch),
        .rolling_count (in_data_reg.rolling_count),
        .time_now      (in_data_reg.time_now),
        .timeout       (sw_timeout_reg),
        .status        (switch_trk)
    );

    assign fault = body_trk.stale || switch_trk.stale ||
                   body_trk.cnt_fault || switch_trk.cnt_fault;
    assign door_open = body_reg.driver_door_open || body_reg.passenger_door_open;

    always_comb begin
        body_next   = body_reg;
        switch_next = switch_reg;
        lock_next   = lock_reg;
        alive_next  = alive_reg;

        result.mode         = MODE_FAULT;
        result.cabin_light  = 1'b0;
        result.head_lamps   = 1'b0;
        result.hazard_lamps = 1'b0;
        result.diag_fault   = fault;

        if (advance && is_body) begin
            body_next.driver_door_open    = in_data_reg.driver_door_open;
            body_next.passenger_door_open = in_data_reg.passenger_door_open;
            body_next.ambient_level       = in_data_reg.ambient_level;
            body_next.ignition            = in_data_reg.ignition;
        end
        if (advance && is_switch) begin
            switch_next.unlock_press  = in_data_reg.unlock_press;
            switch_next.lock_press    = in_data_reg.lock_press;
            switch_next.hazard_press  = in_data_reg.hazard_press;
            switch_next.manual_lights = in_data_reg.manual_lights;
            switch_next.auto_lights   = in_data_reg.auto_lights;
        end

        if (body_trk.seen && switch_trk.seen) begin
            result.hazard_lamps = switch_reg.hazard_press;
            if (!fault) begin
                // unlock wins over lock, lock only with both doors shut
                if (advance && is_tick) begin
                    if (switch_reg.unlock_press) begin
                        lock_next = 1'b0;
                    end else if (switch_reg.lock_press && !door_open) begin
                        lock_next = 1'b1;
                    end
                end
                result.cabin_light = door_open;
                result.head_lamps  = switch_reg.manual_lights ||
                                     (switch_reg.auto_lights &&
                                      (body_reg.ambient_level <= dark_reg));
                result.mode = body_reg.ignition ? MODE_DRIVE : MODE_OFF;
            end
        end

        if (advance && is_tick) begin
            alive_next = alive_reg + 4'd1;
        end
        result.locked       = lock_next;
        result.status_count = alive_next;
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && is_tick) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            in_timeout_reg <= INPUT_TIMEOUT_RESET;
            sw_timeout_reg <= SWITCH_TIMEOUT_RESET;
            dark_reg       <= DARKNESS_RESET;
            body_reg       <= '0;
            switch_reg     <= '0;
            lock_reg       <= 1'b0;
            alive_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            body_reg      <= body_next;
            switch_reg    <= switch_next;
            lock_reg      <= lock_next;
            alive_reg     <= alive_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_INPUT_TIMEOUT:  in_timeout_reg <= cfg_wr_data;
                    CFG_SWITCH_TIMEOUT: sw_timeout_reg <= cfg_wr_data;
                    CFG_DARKNESS:       dark_reg       <= cfg_wr_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && is_tick) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_fault_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.diag_fault == (m_data.mode == MODE_FAULT)))
        else $error("diag_fault and fault mode disagree");

    a_fault_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.diag_fault) |-> (!m_data.cabin_light && !m_data.head_lamps))
        else $error("lights on under fault");

    a_tick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_tick) |=> m_valid)
        else $error("tick left no result");

    a_lock_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && is_tick && !fault) |=> $stable(lock_reg))
        else $error("lock latch moved without a healthy tick");

    a_msg_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !is_tick && !(m_valid && !m_ready)) |=> !m_valid)
        else $error("message produced a result");

endmodule

FILE: tb/body_control_supervisor_test.sv
`timescale 1ns / 1ps

module body_control_supervisor_test;
    import bcs_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam bcs_switch_t SW_UNLOCK = 5'b10000;
    localparam bcs_switch_t SW_LOCK   = 5'b01000;
    localparam bcs_switch_t SW_HAZARD = 5'b00100;
    localparam bcs_switch_t SW_MANUAL = 5'b00010;
    localparam bcs_switch_t SW_AUTO   = 5'b00001;

    localparam int HOLD_CYCLES = 300;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    bcs_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    bcs_out_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data = '0;

    body_control_supervisor dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // supervisor state as the block should hold it
    logic [15:0] limit_body = INPUT_TIMEOUT_RESET;
    logic [15:0] limit_switch = SWITCH_TIMEOUT_RESET;
    logic [6:0] dark_level = DARKNESS_RESET;
    logic body_seen = 1'b0;
    logic switch_seen = 1'b0;
    logic [3:0] body_cnt = '0;
    logic [3:0] switch_cnt = '0;
    logic body_cnt_fault = 1'b0;
    logic switch_cnt_fault = 1'b0;
    logic [31:0] body_at = '0;
    logic [31:0] switch_at = '0;
    bcs_body_t body_msg = '0;
    bcs_switch_t switch_msg = '0;
    logic lock_latch = 1'b0;
    logic [3:0] alive_count = '0;

    bcs_out_t status_due[$];
    bcs_in_t pending_items[$];
    int failures = 0;

    // stimulus side
    logic [31:0] now_ms;
    logic [3:0] body_next = 4'hF;
    logic [3:0] switch_next = 4'hF;
    int unsigned send_idle_max = 19;
    int unsigned recv_idle_max = 19;
    int hold_requests = 0;

    // handshake bookkeeping
    logic s_taken = 1'b0;
    logic m_taken = 1'b0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned hold_left = 0;
    int hold_served = 0;

    function automatic logic is_stale(logic seen, logic [31:0] now, logic [31:0] arrival,
                                      logic [15:0] limit);
        logic [31:0] elapsed;
        elapsed = now - arrival;
        return !seen || (elapsed > {16'd0, limit});
    endfunction

    function automatic void supervise(bcs_in_t item);
        bcs_out_t st;
        logic fault;
        logic door_open;
        case (item.operation)
            OP_BODY: begin
                if (body_seen && item.rolling_count != body_cnt + 4'd1)
                    body_cnt_fault = 1'b1;
                body_cnt = item.rolling_count;
                body_msg.driver_door_open = item.driver_door_open;
                body_msg.passenger_door_open = item.passenger_door_open;
                body_msg.ambient_level = item.ambient_level;
                body_msg.ignition = item.ignition;
                body_at = item.time_now;
                body_seen = 1'b1;
            end
            OP_SWITCH: begin
                if (switch_seen && item.rolling_count != switch_cnt + 4'd1)
                    switch_cnt_fault = 1'b1;
                switch_cnt = item.rolling_count;
                switch_msg.unlock_press = item.unlock_press;
                switch_msg.lock_press = item.lock_press;
                switch_msg.hazard_press = item.hazard_press;
                switch_msg.manual_lights = item.manual_lights;
                switch_msg.auto_lights = item.auto_lights;
                switch_at = item.time_now;
                switch_seen = 1'b1;
            end
            OP_TICK: begin
                fault = is_stale(body_seen, item.time_now, body_at, limit_body)
                     || is_stale(switch_seen, item.time_now, switch_at, limit_switch)
                     || body_cnt_fault || switch_cnt_fault;
                st = '0;
                st.mode = MODE_FAULT;
                if (body_seen && switch_seen) begin
                    door_open = body_msg.driver_door_open | body_msg.passenger_door_open;
                    st.hazard_lamps = switch_msg.hazard_press;
                    // under a fault the latch is frozen and the cabin light and head lamps stay dark
                    if (!fault) begin
                        if (switch_msg.unlock_press)
                            lock_latch = 1'b0;
                        else if (switch_msg.lock_press && !door_open)
                            lock_latch = 1'b1;
                        st.cabin_light = door_open;
                        st.head_lamps = switch_msg.manual_lights
                            || (switch_msg.auto_lights && body_msg.ambient_level <= dark_level);
                        st.mode = body_msg.ignition ? MODE_DRIVE : MODE_OFF;
                    end
                end
                alive_count = alive_count + 4'd1;
                st.locked = lock_latch;
                st.diag_fault = fault;
                st.status_count = alive_count;
                status_due.push_back(st);
            end
            default: ;
        endcase
    endfunction

    task automatic compare_field(string field, logic [3:0] want, logic [3:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        bcs_out_t want;
        s_taken <= aresetn && s_valid && s_ready;
        m_taken <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready)
            supervise(s_data);
        if (aresetn && m_valid && m_ready) begin
            if (status_due.size() == 0) begin
                $error("status transfer with none outstanding: %h", m_data);
                failures++;
            end else begin
                want = status_due.pop_front();
                compare_field("mode", 4'(want.mode), 4'(m_data.mode));
                compare_field("locked", 4'(want.locked), 4'(m_data.locked));
                compare_field("cabin_light", 4'(want.cabin_light), 4'(m_data.cabin_light));
                compare_field("head_lamps", 4'(want.head_lamps), 4'(m_data.head_lamps));
                compare_field("hazard_lamps", 4'(want.hazard_lamps),
                              4'(m_data.hazard_lamps));
                compare_field("diag_fault", 4'(want.diag_fault), 4'(m_data.diag_fault));
                compare_field("status_count", want.status_count, m_data.status_count);
            end
        end
    end

    always @(negedge aclk) begin : sender
        int unsigned pause;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_taken) begin
            // offer stands until the transfer
        end else if (send_wait > 0) begin
            send_wait <= send_wait - 1;
            s_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
            s_data <= pending_items.pop_front();
            s_valid <= 1'b1;
            pause = $urandom_range(0, send_idle_max);
            send_wait <= pause;
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin : receiver
        int unsigned pause;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            m_ready <= 1'b0;
        end else if (m_taken) begin
            pause = $urandom_range(0, recv_idle_max);
            if (pause == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                recv_wait <= pause - 1;
            end
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic bcs_in_t random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(bcs_in_t)-1:0];
    endfunction

    function automatic bcs_in_t body_item(logic [31:0] at, logic drv, logic pas,
                                          logic [6:0] amb, logic ign);
        bcs_in_t item;
        item = random_item();
        item.operation = OP_BODY;
        item.time_now = at;
        item.rolling_count = body_next;
        item.driver_door_open = drv;
        item.passenger_door_open = pas;
        item.ambient_level = amb;
        item.ignition = ign;
        return item;
    endfunction

    function automatic bcs_in_t switch_item(logic [31:0] at, bcs_switch_t sw);
        bcs_in_t item;
        item = random_item();
        item.operation = OP_SWITCH;
        item.time_now = at;
        item.rolling_count = switch_next;
        item.unlock_press = sw.unlock_press;
        item.lock_press = sw.lock_press;
        item.hazard_press = sw.hazard_press;
        item.manual_lights = sw.manual_lights;
        item.auto_lights = sw.auto_lights;
        return item;
    endfunction

    function automatic bcs_in_t tick_item(logic [31:0] at);
        bcs_in_t item;
        item = random_item();
        item.operation = OP_TICK;
        item.time_now = at;
        return item;
    endfunction

    function automatic void offer(bcs_in_t item);
        if (item.operation == OP_BODY)
            body_next = item.rolling_count + 4'd1;
        else if (item.operation == OP_SWITCH)
            switch_next = item.rolling_count + 4'd1;
        pending_items.push_back(item);
    endfunction

    function automatic void step_time();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            now_ms = now_ms + $urandom_range(0, 40);
        else if (pick < 97)
            now_ms = now_ms + $urandom_range(0, 130);
        else
            now_ms = now_ms + $urandom;
    endfunction

    task automatic random_traffic(int count, int break_pct);
        bcs_in_t item;
        int unsigned pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            step_time();
            if (pick < 35)
                item = body_item(now_ms, $urandom_range(0, 9) < 3, $urandom_range(0, 9) < 3,
                                 7'($urandom), 1'($urandom));
            else if (pick < 70)
                item = switch_item(now_ms, 5'($urandom));
            else if (pick < 95)
                item = tick_item(now_ms);
            else if (pick < 97) begin
                item = random_item();
                item.operation = OP_RESERVED;
            end else if (pick < 98)
                item = tick_item($urandom);
            else if (pick < 99)
                item = body_item($urandom, 1'($urandom), 1'($urandom), 7'($urandom),
                                 1'($urandom));
            else
                item = switch_item($urandom, 5'($urandom));
            if ((item.operation == OP_BODY || item.operation == OP_SWITCH)
                    && $urandom_range(0, 99) < break_pct)
                item.rolling_count = item.rolling_count + 4'($urandom_range(1, 15));
            offer(item);
        end
    endtask

    task automatic wait_quiet();
        while (pending_items.size() != 0 || s_valid || status_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        case (idx)
            CFG_INPUT_TIMEOUT:  limit_body = data;
            CFG_SWITCH_TIMEOUT: limit_switch = data;
            CFG_DARKNESS:       dark_level = data[6:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(logic [15:0] t_body, logic [15:0] t_switch, logic [6:0] dark);
        wait_quiet();
        // a message may still sit in the input register
        repeat (4) @(negedge aclk);
        write_reg(CFG_INPUT_TIMEOUT, t_body);
        write_reg(CFG_SWITCH_TIMEOUT, t_switch);
        write_reg(CFG_DARKNESS, {9'($urandom), dark});
    endtask

    initial begin : stimulus
        bcs_in_t item;
        logic [31:0] t;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // start just below the wrap so the early ticks cross zero
        t = 32'hFFFF_FFC0;
        offer(tick_item(t));
        item = '1;
        offer(item);
        offer(body_item(t + 2, 1'b0, 1'b0, 7'd30, 1'b1));
        offer(tick_item(t + 5));
        offer(switch_item(t + 10, SW_LOCK));
        offer(tick_item(t + 20));
        offer(switch_item(t + 30, SW_UNLOCK | SW_LOCK | SW_AUTO | SW_HAZARD));
        offer(body_item(t + 30, 1'b1, 1'b0, 7'd30, 1'b0));
        offer(tick_item(t + 40));
        offer(body_item(t + 50, 1'b0, 1'b0, 7'd31, 1'b1));
        offer(switch_item(t + 50, SW_LOCK | SW_AUTO));
        offer(tick_item(t + 60));
        offer(switch_item(t + 70, SW_UNLOCK));
        offer(tick_item(t + 75));
        // lock request with a door open must leave the latch open
        offer(body_item(t + 80, 1'b0, 1'b1, 7'd0, 1'b1));
        offer(switch_item(t + 80, SW_LOCK | SW_MANUAL | SW_HAZARD));
        offer(tick_item(t + 90));
        offer(tick_item(t + 180));
        offer(tick_item(t + 181));
        offer(body_item(t + 200, 1'b1, 1'b1, 7'd127, 1'b1));
        offer(switch_item(t + 200, SW_UNLOCK | SW_LOCK | SW_HAZARD | SW_MANUAL | SW_AUTO));
        offer(tick_item(t + 200));
        now_ms = t + 200;

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: configure(16'd0, 16'd0, 7'd0);
                1: configure(16'hFFFF, 16'hFFFF, 7'd100);
                2: configure(INPUT_TIMEOUT_RESET, SWITCH_TIMEOUT_RESET, DARKNESS_RESET);
                3: configure(16'd40, 16'd300, 7'd127);
                default: configure(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                                   7'($urandom_range(0, 127)));
            endcase
            case (phase % 4)
                0: begin
                    send_idle_max = 19;
                    recv_idle_max = 19;
                end
                1: begin
                    send_idle_max = 0;
                    recv_idle_max = 0;
                end
                2: begin
                    // receiver stalls long while items keep coming, so the input backs up
                    send_idle_max = 0;
                    recv_idle_max = 19;
                    hold_requests++;
                end
                default: begin
                    send_idle_max = 19;
                    recv_idle_max = 0;
                end
            endcase
            random_traffic(155, 0);
        end

        // broken alive counters last, since their fault stays until reset
        configure(INPUT_TIMEOUT_RESET, SWITCH_TIMEOUT_RESET, DARKNESS_RESET);
        send_idle_max = 19;
        recv_idle_max = 19;
        random_traffic(90, 15);

        wait_quiet();
        repeat (10) @(posedge aclk);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: body_control_supervisor.f
hdl/bcs_pkg.sv
hdl/bcs_msg_tracker.sv
hdl/body_control_supervisor.sv
tb/body_control_supervisor_test.sv
